/* hdl/mte_pkg.sv */
package mte_pkg;

	// Field widths of one feedback report and one result
	localparam int POS_W     = 13;
	localparam int COUNT_W   = 8;
	localparam int TURN_W    = 32;
	localparam int DIFF_W    = 14;
	localparam int WIDE_W    = 15;
	localparam int TOTAL_W   = 46;
	localparam int SLOT_W    = 3;
	localparam int SAMPLE_W  = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 4;

	// Register map: index taken from paddr[2]
	localparam logic REG_CALIBRATION = 1'b0;

	// Encoder and counter constants
	localparam logic [COUNT_W-1:0] CAL_RESET  = 8'd50;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
	localparam logic signed [WIDE_W-1:0] HALF_TURN   = 15'sd4096;
	localparam logic signed [WIDE_W-1:0] COUNTS_TURN = 15'sd8192;
	localparam logic signed [TURN_W-1:0] TURN_MIN = 32'sh8000_0000;
	localparam logic signed [TURN_W-1:0] TURN_MAX = 32'sh7FFF_FFFF;

	// Per-slot tracking state, one memory word
	typedef struct packed {
		logic [COUNT_W-1:0]       report_count;
		logic [POS_W-1:0]         last_position;
		logic [POS_W-1:0]         zero_offset;
		logic signed [TURN_W-1:0] turns;
	} slot_state_t;

endpackage

/* hdl/multiturn_encoder_tracker.sv */
// Multi-turn encoder tracker. Each input word is one motor feedback report for a slot
// (position, speed, current); each report yields exactly one result word in order. A slot
// first records its zero offset for as long as its report count is at or below the
// calibration_messages register (reset 50), then unwraps the 13-bit position into a signed
// delta and a saturating turn count, and reports turns*8192 + position - offset. The block
// takes one word per clock cycle while the result output is not stalled, on any mix of slots,
// back to back; a result is registered in each pipeline stage and offered from the output
// register. That rate comes from the per-slot state memory: one read and one write per cycle,
// with the last write forwarded to a report of the same slot that follows directly. Per-slot
// valid bits make every slot read as zero after reset, so no clearing pass is needed. Slots
// at or above MOTOR_SLOTS leave the state alone and return zero delta, turns and total
// position. Write calibration_messages only while no report is in flight.
module multiturn_encoder_tracker #(
	parameter int MOTOR_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// report input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // encoder_position[12:0], motor_speed[28:13], drive_current[44:29]
	input  logic [2:0]  s_tuser,   // motor_slot[2:0]
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [127:0] m_tdata,  // position_delta[13:0], turn_count[45:14],
	                               // total_position[91:46], speed_out[107:92],
	                               // current_out[123:108]
	output logic [3:0]  m_tuser,   // slot_out[2:0], calibrating[3]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOT_AW = ($clog2(MOTOR_SLOTS) > 0) ? $clog2(MOTOR_SLOTS) : 1;
	localparam int STATE_W = $bits(mte_pkg::slot_state_t);

	// Configuration register
	logic [mte_pkg::COUNT_W-1:0] cal_msgs_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_msgs_q <= mte_pkg::CAL_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == mte_pkg::REG_CALIBRATION) begin
			cal_msgs_q <= pwdata[mte_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == mte_pkg::REG_CALIBRATION) begin
			prdata = {{(32 - mte_pkg::COUNT_W){1'b0}}, cal_msgs_q};
		end
	end

	// Pipeline control
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;
	logic adv_s1, take_in;

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign take_in  = s_tvalid && s_tready;
	assign adv_s1   = valid_s1 && ready_s2;

	// Stage 1 payload: report waiting on its state read
	logic [mte_pkg::SLOT_W-1:0]   slot_s1;
	logic [mte_pkg::POS_W-1:0]    pos_s1;
	logic [mte_pkg::SAMPLE_W-1:0] speed_s1, current_s1;

	always_ff @(posedge clk) begin
		if (take_in) begin
			slot_s1    <= s_tuser;
			pos_s1     <= s_tdata[12:0];
			speed_s1   <= s_tdata[28:13];
			current_s1 <= s_tdata[44:29];
		end
	end

	// State memory
	logic               ram_we;
	logic [SLOT_AW-1:0] addr_s1;
	logic [STATE_W-1:0] ram_wdata, ram_rdata;

	mte_ram #(
		.WIDTH(STATE_W),
		.DEPTH(MOTOR_SLOTS)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.re   (take_in),
		.raddr(SLOT_AW'(s_tuser)),
		.rdata(ram_rdata)
	);

	// Last write, forwarded to a read that raced it
	logic               fwd_v_q;
	logic [SLOT_AW-1:0] fwd_addr_q;
	logic [STATE_W-1:0] fwd_data_q;
	logic [MOTOR_SLOTS-1:0] slot_valid_q;

	// Stage 1: read-modify-write of the slot state
	logic in_range_s1;
	mte_pkg::slot_state_t cur_st, nxt_st;
	logic cal_now;
	logic signed [mte_pkg::WIDE_W-1:0] diff_w, delta_w;
	logic signed [mte_pkg::DIFF_W-1:0] delta_now, offdiff_now;
	logic signed [mte_pkg::TURN_W-1:0] turns_now;

	assign addr_s1     = SLOT_AW'(slot_s1);
	assign in_range_s1 = 32'(slot_s1) < MOTOR_SLOTS;

	always_comb begin
		priority if (fwd_v_q && fwd_addr_q == addr_s1) begin
			cur_st = mte_pkg::slot_state_t'(fwd_data_q);
		end else if (in_range_s1 && slot_valid_q[addr_s1]) begin
			cur_st = mte_pkg::slot_state_t'(ram_rdata);
		end else begin
			cur_st = '0;
		end
	end

	always_comb begin
		nxt_st  = cur_st;
		cal_now = cur_st.report_count <= cal_msgs_q;
		diff_w  = $signed({2'b00, pos_s1}) - $signed({2'b00, cur_st.last_position});
		delta_w = '0;
		if (cur_st.report_count != mte_pkg::COUNT_MAX) begin
			nxt_st.report_count = cur_st.report_count + 1'b1;
		end
		nxt_st.last_position = pos_s1;
		if (cal_now) begin
			nxt_st.zero_offset = pos_s1;
		end else begin
			// unwrap across the turn boundary
			priority if (diff_w > mte_pkg::HALF_TURN) begin
				delta_w = diff_w - mte_pkg::COUNTS_TURN;
				if (cur_st.turns != mte_pkg::TURN_MIN) begin
					nxt_st.turns = cur_st.turns - 32'sd1;
				end
			end else if (diff_w < -mte_pkg::HALF_TURN) begin
				delta_w = diff_w + mte_pkg::COUNTS_TURN;
				if (cur_st.turns != mte_pkg::TURN_MAX) begin
					nxt_st.turns = cur_st.turns + 32'sd1;
				end
			end else begin
				delta_w = diff_w;
			end
		end
	end

	// Result fields; a slot out of range gives zeros
	always_comb begin
		if (in_range_s1) begin
			delta_now   = delta_w[mte_pkg::DIFF_W-1:0];
			turns_now   = nxt_st.turns;
			offdiff_now = $signed({1'b0, pos_s1}) - $signed({1'b0, nxt_st.zero_offset});
		end else begin
			delta_now   = '0;
			turns_now   = '0;
			offdiff_now = '0;
		end
	end

	assign ram_we    = adv_s1 && in_range_s1;
	assign ram_wdata = nxt_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q      <= 1'b0;
			fwd_addr_q   <= '0;
			slot_valid_q <= '0;
		end else if (ram_we) begin
			fwd_v_q               <= 1'b1;
			fwd_addr_q            <= addr_s1;
			slot_valid_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_data_q <= ram_wdata;
		end
	end

	// Stage 2 payload
	logic [mte_pkg::SLOT_W-1:0]        slot_s2;
	logic                              cal_s2;
	logic signed [mte_pkg::DIFF_W-1:0] delta_s2, offdiff_s2;
	logic signed [mte_pkg::TURN_W-1:0] turns_s2;
	logic [mte_pkg::SAMPLE_W-1:0]      speed_s2, current_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			slot_s2    <= slot_s1;
			cal_s2     <= in_range_s1 && cal_now;
			delta_s2   <= delta_now;
			turns_s2   <= turns_now;
			offdiff_s2 <= offdiff_now;
			speed_s2   <= speed_s1;
			current_s2 <= current_s1;
		end
	end

	// Stage 3: output register with the total position
	logic [mte_pkg::SLOT_W-1:0]         slot_s3;
	logic                               cal_s3;
	logic signed [mte_pkg::DIFF_W-1:0]  delta_s3;
	logic signed [mte_pkg::TURN_W-1:0]  turns_s3;
	logic signed [mte_pkg::TOTAL_W-1:0] total_s3;
	logic [mte_pkg::SAMPLE_W-1:0]       speed_s3, current_s3;
	logic adv_s2;

	assign adv_s2 = valid_s2 && ready_s3;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			slot_s3    <= slot_s2;
			cal_s3     <= cal_s2;
			delta_s3   <= delta_s2;
			turns_s3   <= turns_s2;
			total_s3   <= $signed({turns_s2[mte_pkg::TURN_W-1], turns_s2,
				{mte_pkg::POS_W{1'b0}}})
				+ $signed({{(mte_pkg::TOTAL_W - mte_pkg::DIFF_W){offdiff_s2[mte_pkg::DIFF_W-1]}},
				offdiff_s2});
			speed_s3   <= speed_s2;
			current_s3 <= current_s2;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tuser  = {cal_s3, slot_s3};
	assign m_tdata  = {4'b0000, current_s3, speed_s3, total_s3, turns_s3, delta_s3};

	// Checks
	a_cal_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && cal_s3 |-> delta_s3 == '0)
		else $error("calibrating result carries a nonzero delta");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && valid_s3 && !m_tready)
		else $error("input stalled with room in the pipeline");

	a_fwd_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> fwd_v_q && fwd_addr_q == $past(addr_s1) && fwd_data_q == $past(ram_wdata))
		else $error("forward register missed a state write");

	a_out_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && 32'(slot_s3) >= MOTOR_SLOTS |-> turns_s3 == '0 && total_s3 == '0 && !cal_s3)
		else $error("result for an absent slot is not zero");

endmodule

/* hdl/mte_ram.sv */
module mte_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 8,
	localparam int AW = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* tb/multiturn_encoder_tracker_test.sv */
module multiturn_encoder_tracker_test;

	localparam int DRAIN_CYCLES = 8;
	localparam int SLOT_COUNT = 8;

	typedef struct packed {
		logic [mte_pkg::SLOT_W-1:0]          slot;
		logic                                calibrating;
		logic signed [mte_pkg::DIFF_W-1:0]   delta;
		logic signed [mte_pkg::TURN_W-1:0]   turns;
		logic signed [mte_pkg::TOTAL_W-1:0]  total;
		logic signed [mte_pkg::SAMPLE_W-1:0] speed;
		logic signed [mte_pkg::SAMPLE_W-1:0] current;
	} tracker_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mte_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [mte_pkg::SLOT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mte_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [mte_pkg::OUT_USER_W-1:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// tracker copy: register and per-slot state
	logic [mte_pkg::COUNT_W-1:0] cal_limit = mte_pkg::CAL_RESET;
	logic [mte_pkg::COUNT_W-1:0] slot_reports [SLOT_COUNT];
	logic [mte_pkg::POS_W-1:0] slot_last [SLOT_COUNT];
	logic [mte_pkg::POS_W-1:0] slot_zero [SLOT_COUNT];
	logic signed [mte_pkg::TURN_W-1:0] slot_turns [SLOT_COUNT];

	// stimulus bookkeeping
	logic [mte_pkg::POS_W-1:0] motor_angle [SLOT_COUNT];
	tracker_result_t expected_results [$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;
	logic hold_off = 1'b0;

	multiturn_encoder_tracker #(.MOTOR_SLOTS(SLOT_COUNT)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_reports[i] = '0;
			slot_last[i] = '0;
			slot_zero[i] = '0;
			slot_turns[i] = '0;
			motor_angle[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#1000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Update one slot and work out the word it should produce
	function automatic tracker_result_t predict_report(
		input logic [mte_pkg::SLOT_W-1:0] slot,
		input logic [mte_pkg::POS_W-1:0] pos, input logic [mte_pkg::SAMPLE_W-1:0] spd,
		input logic [mte_pkg::SAMPLE_W-1:0] cur);
		tracker_result_t r;
		logic [mte_pkg::COUNT_W-1:0] prev;
		int diff;
		int step;
		longint sum;
		step = 0;
		prev = slot_reports[slot];
		r.calibrating = 1'b0;
		if (prev != mte_pkg::COUNT_MAX) slot_reports[slot] = prev + 1'b1;
		if (prev <= cal_limit) begin
			r.calibrating = 1'b1;
			slot_last[slot] = pos;
			slot_zero[slot] = pos;
		end else begin
			diff = int'(pos) - int'(slot_last[slot]);
			slot_last[slot] = pos;
			if (diff > int'(mte_pkg::HALF_TURN)) begin
				step = diff - int'(mte_pkg::COUNTS_TURN);
				if (slot_turns[slot] != mte_pkg::TURN_MIN)
					slot_turns[slot] = slot_turns[slot] - 1;
			end else if (diff < -int'(mte_pkg::HALF_TURN)) begin
				step = diff + int'(mte_pkg::COUNTS_TURN);
				if (slot_turns[slot] != mte_pkg::TURN_MAX)
					slot_turns[slot] = slot_turns[slot] + 1;
			end else begin
				step = diff;
			end
		end
		sum = longint'(slot_turns[slot]) * longint'(mte_pkg::COUNTS_TURN) + longint'(pos)
			- longint'(slot_zero[slot]);
		r.slot = slot;
		r.delta = step[mte_pkg::DIFF_W-1:0];
		r.turns = slot_turns[slot];
		r.total = sum[mte_pkg::TOTAL_W-1:0];
		r.speed = spd;
		r.current = cur;
		return r;
	endfunction

	// Offer one report, hold it until taken
	task automatic send_report(input logic [mte_pkg::SLOT_W-1:0] slot,
		input logic [mte_pkg::POS_W-1:0] pos,
		input logic [mte_pkg::SAMPLE_W-1:0] spd, input logic [mte_pkg::SAMPLE_W-1:0] cur);
		bit taken;
		taken = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= slot;
		s_tdata <= {3'b000, cur, spd, pos};
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			if (taken) expected_results.push_back(predict_report(slot, pos, spd, cur));
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write: setup then access cycle, only while idle
	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		wait_drained();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr[2] == mte_pkg::REG_CALIBRATION) cal_limit = value[mte_pkg::COUNT_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void note_field(input string name, input longint expv,
		input longint actv);
		if (expv != actv) begin
			if (mismatch_count < 10)
				$display("mismatch %s: expected %0d, got %0d", name, expv, actv);
			mismatch_count++;
		end
	endfunction

	// Compare one output word with the oldest expectation
	task automatic check_result();
		tracker_result_t want;
		tracker_result_t got;
		got.slot = m_tuser[2:0];
		got.calibrating = m_tuser[3];
		got.delta = m_tdata[13:0];
		got.turns = m_tdata[45:14];
		got.total = m_tdata[91:46];
		got.speed = m_tdata[107:92];
		got.current = m_tdata[123:108];
		if (expected_results.size() == 0) begin
			if (mismatch_count < 10) $display("unexpected result word for slot %0d", got.slot);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			note_field("slot_out", want.slot, got.slot);
			note_field("calibrating", want.calibrating, got.calibrating);
			note_field("position_delta", want.delta, got.delta);
			note_field("turn_count", want.turns, got.turns);
			note_field("total_position", want.total, got.total);
			note_field("speed_out", want.speed, got.speed);
			note_field("current_out", want.current, got.current);
		end
	endtask

	// Sample the result handshake on the falling edge ahead of the rising edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result();
	end

	// Receiver ready, with random stalls and the long hold-off
	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// Count out a requested hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				hold_off = 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_off = 1'b0;
				hold_len = 0;
			end
		end
	end

	// Random traffic: mostly a turning motor, some half-turn jumps, some noise
	task automatic run_random_phase(input int count);
		logic [mte_pkg::SLOT_W-1:0] slot;
		logic [mte_pkg::POS_W-1:0] next;
		int kind;
		int step;
		for (int i = 0; i < count; i++) begin
			slot = 3'($urandom_range(SLOT_COUNT - 1));
			kind = $urandom_range(99);
			if (kind < 70) begin
				step = int'($urandom_range(1200)) - 600;
				next = motor_angle[slot] + step[mte_pkg::POS_W-1:0];
			end else if (kind < 85) begin
				step = int'(mte_pkg::HALF_TURN) + int'($urandom_range(12)) - 6;
				if ($urandom_range(1)) step = -step;
				next = motor_angle[slot] + step[mte_pkg::POS_W-1:0];
			end else begin
				next = 13'($urandom_range(8191));
			end
			motor_angle[slot] = next;
			send_report(slot, next, 16'($urandom()), 16'($urandom()));
		end
	endtask

	// Reset window: every report calibrates, field extremes
	task automatic test_calibration_window();
		send_report(3'd0, 13'd0, 16'h8000, 16'h7FFF);
		send_report(3'd0, 13'd8191, 16'h7FFF, 16'h8000);
		send_report(3'd1, 13'd4096, 16'h0000, 16'h0000);
		send_report(3'd2, 13'h0AAA, 16'h5555, 16'hAAAA);
		send_report(3'd3, 13'h1555, 16'hAAAA, 16'h5555);
		send_report(3'd4, 13'h1FFF, 16'hFFFF, 16'hFFFF);
		send_report(3'd5, 13'h0001, 16'h0001, 16'h0001);
		send_report(3'd6, 13'h1000, 16'hFFFE, 16'h8001);
		send_report(3'd7, 13'h0FFF, 16'h7FFE, 16'h0002);
	endtask

	// Unwrap boundaries: exactly half a turn stays, one more wraps
	task automatic test_wrap_edges();
		write_register(3'd0, 32'h0000_0000);
		write_register(3'd4, 32'h0000_00C8);
		send_report(3'd2, 13'd0, 16'h1234, 16'h4321);
		send_report(3'd2, 13'd4096, 16'h1234, 16'h4321);
		send_report(3'd2, 13'd0, 16'h1234, 16'h4321);
		send_report(3'd2, 13'd4097, 16'h1234, 16'h4321);
		send_report(3'd2, 13'd0, 16'h1234, 16'h4321);
		send_report(3'd2, 13'd8191, 16'h1234, 16'h4321);
		send_report(3'd2, 13'd0, 16'h1234, 16'h4321);
		send_report(3'd2, 13'd8191, 16'h1234, 16'h4321);
		send_report(3'd7, 13'd8191, 16'h8000, 16'h8000);
		send_report(3'd7, 13'd1, 16'h7FFF, 16'h7FFF);
	endtask

	// Report count saturates: largest window ends at 255, 255 never ends
	task automatic test_count_saturation();
		write_register(3'd0, {24'hA5A5A5, 8'd254});
		for (int i = 0; i < 300; i++)
			send_report(3'd6, 13'($urandom_range(8191)), 16'($urandom()), 16'($urandom()));
		write_register(3'd0, 32'hFFFF_FFFF);
		for (int i = 0; i < 20; i++)
			send_report(3'($urandom_range(SLOT_COUNT - 1)), 13'($urandom_range(8191)),
				16'($urandom()), 16'($urandom()));
	endtask

	task automatic test_random_traffic();
		write_register(3'd0, 32'd3);
		run_random_phase(300);
		send_idle_pct = 51;
		recv_idle_pct = 15;
		write_register(3'd0, {24'($urandom_range(255)), 8'($urandom_range(254))});
		run_random_phase(300);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(3'd0, 32'd0);
		run_random_phase(300);
	endtask

	// Fill the block behind a stalled receiver, then refill from empty
	task automatic test_backpressure();
		hold_len = 300;
		run_random_phase(100);
		wait_drained();
		run_random_phase(50);
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		send_idle_pct = 15;
		recv_idle_pct = 51;
		test_calibration_window();
		test_wrap_edges();
		test_count_saturation();
		test_random_traffic();
		test_backpressure();
		wait_drained();
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
